// File: rtl/core/fp16_q13_dot_product_lanes_unit_assert.svh
// Assertion macros for the fp16 Q2.13 dot product unit.
// Included by the top-level RTL file for its assertions; expects clk and rst_n in scope.
`ifndef FP16_Q13_DOT_PRODUCT_LANES_UNIT_ASSERT_SVH
`define FP16_Q13_DOT_PRODUCT_LANES_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low
`define FQDP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fqdp assertion failed");
// Next-cycle implication, disabled while reset is low
`define FQDP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fqdp assertion failed");
`else
`define FQDP_ASSERT_IMP(lbl, ante, cons)
`define FQDP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/fqdp_pkg.sv
// Shared types, constants and the fp16 to Q2.13 conversion for the dot product unit.
// No dependencies.
package fqdp_pkg;

  localparam logic signed [15:0] Q13_POS_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q13_NEG_MAX = 16'sh8000;
  localparam logic [4:0] HALF_EXP_SPECIAL = 5'd31;
  localparam logic [4:0] HALF_EXP_SAT     = 5'd17;

  // Pipeline advance controls shared by all lanes
  typedef struct packed {
    logic ld2;     // operand stage loads
    logic ld3;     // product stage loads
    logic acc_en;  // product stage drains into the accumulator
    logic clr;     // draining item is the last one: clear after it
    logic ld4;     // final sum stage loads
    logic ld5;     // magnitude stage loads
    logic ld6;     // first rounding stage loads
    logic ldo;     // output register loads
  } ctl_t;

  // fp16 bits to Q2.13: scale by 8192, round half away from zero, saturate
  function automatic logic signed [15:0] half_to_q13(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  mt;
    logic [10:0] sig;
    logic [3:0]  sh;
    logic [25:0] x;
    logic [15:0] mag;
    logic signed [15:0] res;
    sgn = h[15];
    ex  = h[14:10];
    mt  = h[9:0];
    sig = (ex == 5'd0) ? {1'b0, mt} : {1'b1, mt};
    sh  = (ex == 5'd0) ? 4'd0 : 4'(ex - 5'd1);
    x   = 26'(sig) << sh;
    mag = 16'((x + 26'd1024) >> 11);
    if (ex == HALF_EXP_SPECIAL && mt != 10'd0) begin
      res = 16'sd0;
    end else if (ex >= HALF_EXP_SAT) begin
      res = sgn ? Q13_NEG_MAX : Q13_POS_MAX;
    end else if (sgn) begin
      res = $signed(16'(-mag));
    end else begin
      res = $signed(mag);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/fqdp_if.sv
// Valid/ready channel interfaces for the dot product unit.
// Depends on nothing; LANES sets the width of the lane buses.
interface fqdp_in_if #(parameter int LANES = 4);
  logic                  valid;
  logic                  ready;
  logic [15:0]           a_half;
  logic [LANES*16-1:0]   b_lane;
  logic                  last_term;

  modport source (output valid, a_half, b_lane, last_term, input ready);
  modport sink   (input valid, a_half, b_lane, last_term, output ready);
endinterface

interface fqdp_out_if #(parameter int LANES = 4);
  logic                  valid;
  logic                  ready;
  logic [LANES*16-1:0]   y_lane;

  modport source (output valid, y_lane, input ready);
  modport sink   (input valid, y_lane, output ready);
endinterface

// File: rtl/core/fqdp_lane.sv
// One multiply-accumulate lane: operand conversion, product, accumulator, fp16 output.
// Depends on fqdp_pkg for ctl_t and half_to_q13.
module fqdp_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fqdp_pkg::ctl_t            ctl,
  input  logic [15:0]               b_half,
  input  logic signed [15:0]        a_q,
  output logic [15:0]               y
);
  import fqdp_pkg::*;

  // Shift right with round to nearest, ties to even
  function automatic logic [31:0] rne_shift(input logic [31:0] v, input logic [4:0] sh);
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    q    = v >> sh;
    rem  = v & ((32'd1 << sh) - 32'd1);
    half = (sh == 5'd0) ? 32'd0 : (32'd1 << (sh - 5'd1));
    if (sh != 5'd0 && (rem > half || (rem == half && q[0]))) begin
      q = q + 32'd1;
    end
    return q;
  endfunction

  // Index of the highest set bit, zero for zero
  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic signed [15:0] b_q_r;
  logic signed [31:0] prod_r, prod_nxt;
  logic [31:0]        sum_r, sum_nxt;
  logic [31:0]        fin_r;
  logic               sgn5_r, sgn6_r;
  logic [31:0]        mag5_r, mag5_nxt;
  logic [4:0]         p5_r, p5_nxt;
  logic [31:0]        m6_r, m6_nxt;
  logic [4:0]         p6_r, p6_nxt;
  logic [15:0]        y_r, y_nxt;

  // Multiply and accumulate
  assign prod_nxt = a_q * b_q_r;
  assign sum_nxt  = sum_r + prod_r;

  // Sign and magnitude of the final sum, leading bit position
  always_comb begin
    mag5_nxt = fin_r[31] ? (32'd0 - fin_r) : fin_r;
    p5_nxt   = top_bit(mag5_nxt);
  end

  // Round to 24 significant bits; a carry moves the leading bit up one
  always_comb begin
    logic [4:0]  sh1;
    logic [31:0] qr;
    sh1 = 5'(p5_r - 5'd23);
    qr  = rne_shift(mag5_r, sh1);
    if (p5_r > 5'd23) begin
      m6_nxt = qr << sh1;
      p6_nxt = p5_r + 5'(qr[24]);
    end else begin
      m6_nxt = mag5_r;
      p6_nxt = p5_r;
    end
  end

  // Round to fp16, normal or subnormal, and pack
  always_comb begin
    logic [31:0] r;
    logic [4:0]  e;
    r = rne_shift(m6_r, 5'(p6_r - 5'd10));
    e = 5'(p6_r - 5'd11);
    if (p6_r >= 5'd12) begin
      if (r[11]) begin
        y_nxt = {sgn6_r, 5'(e + 5'd1), 10'd0};
      end else begin
        y_nxt = {sgn6_r, e, r[9:0]};
      end
    end else begin
      y_nxt = {sgn6_r, 15'(rne_shift(m6_r, 5'd2))};
    end
  end

  // Accumulator: cleared at reset and after the last term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.acc_en) begin
      sum_r <= ctl.clr ? 32'd0 : sum_nxt;
    end
  end

  // Advance payload stages
  always_ff @(posedge clk) begin
    if (ctl.ld2) b_q_r <= half_to_q13(b_half);
    if (ctl.ld3) prod_r <= prod_nxt;
    if (ctl.ld4) fin_r <= sum_nxt;
    if (ctl.ld5) begin
      sgn5_r <= fin_r[31];
      mag5_r <= mag5_nxt;
      p5_r   <= p5_nxt;
    end
    if (ctl.ld6) begin
      sgn6_r <= sgn5_r;
      m6_r   <= m6_nxt;
      p6_r   <= p6_nxt;
    end
    if (ctl.ldo) y_r <= y_nxt;
  end

  assign y = y_r;

endmodule

// File: rtl/core/fp16_q13_dot_product_lanes_unit.sv
// Top level of the fp16 Q2.13 dot product unit: handshake, pipeline control, lanes.
// Depends on fqdp_pkg, fqdp_if.sv, fqdp_lane and the assertion macro header.
// Usage: in_ch carries one fp16 left element a_half, LANES fp16 right elements packed
// in b_lane (lane i at bits 16*i+15:16*i) and last_term. A transfer happens when valid
// and ready are both high. Every lane adds the Q2.13 product a*b into its 32-bit sum.
// An item with last_term set closes the dot product: out_ch then presents one result,
// y_lane, the fp16 value of each sum times 2^-26, and the sums restart from zero.
// Stages in order: input, operand, product, final sum, magnitude, rounding, output.
// Throughput: one item per cycle while in_ch.ready is high; each lane's single
// multiplier and accumulator adder take one product per cycle.
// Reset (rst_n low, synchronous): all sums clear and the pipeline empties.
// Receiver stall: a waiting result holds in the output register while the stages
// behind it keep taking items; in_ch.ready drops only when a last item cannot move
// into a full result path behind the stalled output.
`include "fp16_q13_dot_product_lanes_unit_assert.svh"

module fp16_q13_dot_product_lanes_unit #(
  parameter int LANES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  fqdp_in_if.sink        in_ch,
  fqdp_out_if.source     out_ch
);
  import fqdp_pkg::*;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, vo_r;
  logic                    last2_r, last3_r;
  logic [15:0]             a_half_r;
  logic [LANES*16-1:0]     b_lane_r;
  logic                    last1_r;
  logic signed [15:0]      a_q_r;
  logic                    ld1, d3;
  ctl_t                    ctl;
  logic [LANES-1:0][15:0]  y_w;

  // Ready chain from the output back to the input
  always_comb begin
    ctl.ldo    = !vo_r || out_ch.ready;
    ctl.ld6    = !v6_r || ctl.ldo;
    ctl.ld5    = !v5_r || ctl.ld6;
    ctl.ld4    = !v4_r || ctl.ld5;
    d3         = !(v3_r && last3_r) || ctl.ld4;
    ctl.ld3    = !v3_r || d3;
    ctl.ld2    = !v2_r || ctl.ld3;
    ld1        = !v1_r || ctl.ld2;
    ctl.acc_en = v3_r && d3;
    ctl.clr    = last3_r;
  end

  assign in_ch.ready  = ld1;
  assign out_ch.valid = vo_r;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld1)     v1_r <= in_ch.valid;
      if (ctl.ld2) v2_r <= v1_r;
      if (ctl.ld3) v3_r <= v2_r;
      if (ctl.ld4) v4_r <= v3_r && last3_r;
      if (ctl.ld5) v5_r <= v4_r;
      if (ctl.ld6) v6_r <= v5_r;
      if (ctl.ldo) vo_r <= v6_r;
    end
  end

  // Hold the input transfer, convert the left operand
  always_ff @(posedge clk) begin
    if (ld1) begin
      a_half_r <= in_ch.a_half;
      b_lane_r <= in_ch.b_lane;
      last1_r  <= in_ch.last_term;
    end
    if (ctl.ld2) begin
      a_q_r   <= half_to_q13(a_half_r);
      last2_r <= last1_r;
    end
    if (ctl.ld3) last3_r <= last2_r;
  end

  // Lanes
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    fqdp_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .b_half (b_lane_r[16*i +: 16]),
      .a_q    (a_q_r),
      .y      (y_w[i])
    );
  end

  assign out_ch.y_lane = y_w;

  `FQDP_ASSERT_NXT(a_accept_fills, in_ch.valid && in_ch.ready, v1_r)
  `FQDP_ASSERT_NXT(a_last_holds, v3_r && last3_r && !ctl.ld4, v3_r && last3_r)
  `FQDP_ASSERT_NXT(a_last_moves, v3_r && last3_r && ctl.ld4, v4_r)
  `FQDP_ASSERT_NXT(a_stall_holds, vo_r && !out_ch.ready && v6_r, v6_r && vo_r)

endmodule

// File: sim/fqdp_dot_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the fp16 Q2.13 dot product unit: watches both channels, keeps its own
// lane sums and checks every result transfer. Depends on fqdp_pkg and fqdp_if.sv.
module fqdp_dot_checker #(
  parameter int LANES = 4
) (
  input  logic clk,
  input  logic rst_n,
  fqdp_in_if   in_mon,
  fqdp_out_if  out_mon,
  output int   mismatch_count,
  output int   results_pending
);
  import fqdp_pkg::*;

  logic [31:0]          lane_sum [LANES];
  logic [LANES*16-1:0]  dot_results_q [$];

  // Shift right, round to nearest, ties to even
  function automatic longint unsigned round_shift_even(input longint unsigned v,
                                                       input int sh);
    longint unsigned q, rem, half;
    if (sh == 0) return v;
    q    = v >> sh;
    rem  = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  function automatic int msb_index(input longint unsigned v);
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) return i;
    end
    return 0;
  endfunction

  // fp16 bits to Q2.13: times 8192, round half away from zero, saturate
  function automatic logic signed [15:0] to_q13(input logic [15:0] h);
    longint unsigned sig, mag;
    int shift;
    if (h[14:10] == 5'd31) begin
      // NaN reads as zero, infinity saturates below
      if (h[9:0] != 10'd0) return 16'sd0;
      mag = 40000;
    end else begin
      sig   = (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
      shift = (h[14:10] == 5'd0) ? -11 : int'(h[14:10]) - 12;
      if (shift >= 0) mag = sig << shift;
      else mag = (sig + (64'd1 << (-shift - 1))) >> (-shift);
    end
    if (!h[15]) return (mag > 32767) ? Q13_POS_MAX : 16'(mag);
    if (mag > 32768) mag = 32768;
    return 16'(64'd0 - mag);
  endfunction

  // Accumulator times 2^-26 to fp16, via a 24-bit significand first
  function automatic logic [15:0] to_half(input logic [31:0] acc);
    longint unsigned m, r;
    int p;
    logic [14:0] body;
    m = {32'd0, acc[31] ? (~acc + 32'd1) : acc};
    if (m == 0) return 16'h0000;
    p = msb_index(m);
    if (p > 23) begin
      m = round_shift_even(m, p - 23) << (p - 23);
      p = msb_index(m);
    end
    if (p >= 12) begin
      r = round_shift_even(m, p - 10);
      if (r == 2048) begin
        r = 1024;
        p++;
      end
      body = {5'(p - 11), r[9:0]};
    end else begin
      // fp16 subnormal range: units of 2^-24
      body = 15'(round_shift_even(m, 2));
    end
    return {acc[31], body};
  endfunction

  // Check result transfers, then fold accepted terms into the lane sums
  always @(posedge clk) begin
    logic [LANES*16-1:0] want, got;
    logic signed [15:0]  a_q, b_q;
    logic signed [31:0]  term;
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) lane_sum[i] = 32'd0;
      dot_results_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.y_lane;
        if (dot_results_q.size() == 0) begin
          $error("y_lane: result %h with no dot product pending", got);
          mismatch_count++;
        end else begin
          want = dot_results_q.pop_front();
          for (int i = 0; i < LANES; i++) begin
            if (got[16*i +: 16] !== want[16*i +: 16]) begin
              $error("y_lane%0d: expected %h, actual %h", i, want[16*i +: 16],
                     got[16*i +: 16]);
              mismatch_count++;
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        a_q = to_q13(in_mon.a_half);
        for (int i = 0; i < LANES; i++) begin
          b_q  = to_q13(in_mon.b_lane[16*i +: 16]);
          term = a_q * b_q;
          lane_sum[i] = lane_sum[i] + term;
        end
        // Close the dot product: emit, then restart every sum
        if (in_mon.last_term) begin
          for (int i = 0; i < LANES; i++) begin
            want[16*i +: 16] = to_half(lane_sum[i]);
            lane_sum[i] = 32'd0;
          end
          dot_results_q.push_back(want);
        end
      end
    end
    results_pending = dot_results_q.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the dot product unit test: clock, reset, term stimulus and verdict.
// Depends on fqdp_pkg, fqdp_if.sv, the unit's RTL and fqdp_dot_checker.
module testbench;
  localparam int LANES = 4;

  logic clk;
  logic rst_n;
  logic no_idle;
  int   fail_total;
  int   pending;
  int   sent;
  int   len;

  fqdp_in_if  #(.LANES(LANES)) in_ch ();
  fqdp_out_if #(.LANES(LANES)) out_ch ();

  fp16_q13_dot_product_lanes_unit #(.LANES(LANES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fqdp_dot_checker #(.LANES(LANES)) scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (fail_total),
    .results_pending (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop well past the slowest correct run
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: stall at random except during the no-idle stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = no_idle || ($urandom_range(99) >= 18);
    end
  end

  function automatic logic [LANES*16-1:0] lanes(input logic [15:0] b0, input logic [15:0] b1,
                                                 input logic [15:0] b2, input logic [15:0] b3);
    return {b3, b2, b1, b0};
  endfunction

  // Mostly values within Q2.13 reach, some raw patterns, some special encodings
  function automatic logic [15:0] pick_half();
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) return {1'($urandom), 5'($urandom_range(17)), 10'($urandom)};
    if (kind < 85) return 16'($urandom);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7C00;
      3: return 16'hFC00;
      4: return 16'h7E01;
      5: return 16'h3C00;
      6: return 16'h4400;
      default: return 16'hC400;
    endcase
  endfunction

  // Present one term at the falling edge and hold it until the transfer
  task automatic send_term(input logic [15:0] a, input logic [LANES*16-1:0] b,
                           input logic last);
    while (!no_idle && $urandom_range(99) < 18) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.a_half    = a;
    in_ch.b_lane    = b;
    in_ch.last_term = last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    rst_n           = 1'b0;
    no_idle         = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.a_half    = 16'h0000;
    in_ch.b_lane    = '0;
    in_ch.last_term = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Zeros, signed zero, subnormal operands
    send_term(16'h3C00, lanes(16'h0000, 16'h8000, 16'h0001, 16'h03FF), 1'b1);
    // Half-way operands round away from zero
    send_term(16'h0400, lanes(16'h0400, 16'h8400, 16'h3C00, 16'hBC00), 1'b1);
    // Infinities saturate, NaNs read as zero
    send_term(16'h7C00, lanes(16'h7C00, 16'hFC00, 16'h7E00, 16'hFFFF), 1'b1);
    // Large magnitudes saturate in a three-term dot product
    send_term(16'hFC00, lanes(16'h7BFF, 16'hFBFF, 16'h4400, 16'hC400), 1'b0);
    send_term(16'hC400, lanes(16'hC400, 16'h43FF, 16'h4400, 16'h0001), 1'b0);
    send_term(16'h43FF, lanes(16'h43FF, 16'hC3FF, 16'h3BFF, 16'h7FFF), 1'b1);
    // Negative zero left operand gives all-zero results
    send_term(16'h8000, lanes(16'h3C00, 16'h4400, 16'hC400, 16'h7C00), 1'b1);
    // Two full-scale products land exactly on the most negative sum
    send_term(16'hC400, lanes(16'hC400, 16'hC400, 16'h4400, 16'h1400), 1'b0);
    send_term(16'hC400, lanes(16'hC400, 16'h4400, 16'hC400, 16'h0400), 1'b1);
    // Tiny sums produce fp16 subnormal results
    send_term(16'h1400, lanes(16'h0400, 16'h0800, 16'h8400, 16'h03FF), 1'b1);
    send_term(16'hFFFF, lanes(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8001), 1'b1);
    send_term(16'h3555, lanes(16'h2AAA, 16'hD555, 16'h5555, 16'hAAAA), 1'b1);
    send_term(16'h2E66, lanes(16'h3266, 16'hB266, 16'h3F00, 16'h0200), 1'b0);
    send_term(16'h2E66, lanes(16'h3266, 16'hB266, 16'h3F00, 16'h0200), 1'b1);

    // Random dot products, mostly short with an occasional long one
    sent = 0;
    while (sent < 1340) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int k = 0; k < len; k++) begin
        no_idle = (sent >= 500 && sent < 700);
        send_term(pick_half(), lanes(pick_half(), pick_half(), pick_half(), pick_half()),
                  k == len - 1);
        sent++;
      end
    end

    // Drain: wait for every expected result, then keep watching for strays
    @(negedge clk);
    in_ch.valid = 1'b0;
    no_idle     = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (fail_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
